### rtl/xed_pkg.sv
// shared types, constants and entity tables for the xml entity decoder
// no dependencies; imported by every module of the block
package xed_pkg;

	localparam int EntCount  = 5;
	localparam int HoldDepth = 4;
	localparam int QueueDepth = 2;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] ent_idx_t;
	typedef logic [2:0] pos_t;
	typedef logic [EntCount-1:0] cand_t;

	localparam byte_t AmpChar = 8'h26;
	localparam cand_t AllCand = {EntCount{1'b1}};

	// one unit of output work handed from the front to the back
	typedef struct packed {
		logic                         flush;
		logic [2:0]                   nheld;
		byte_t [HoldDepth-1:0]        held;
		logic                         has_tail;
		logic                         tail_bad;
		byte_t                        tail;
		logic                         last_end;
	} job_t;

	// entity order: lt gt amp quot apos
	function automatic byte_t ent_name(input ent_idx_t ent, input pos_t pos);
		byte_t ch;
		ch = 8'h00;
		case ({ent, pos})
			6'o00: ch = "l";
			6'o01: ch = "t";
			6'o02: ch = ";";
			6'o10: ch = "g";
			6'o11: ch = "t";
			6'o12: ch = ";";
			6'o20: ch = "a";
			6'o21: ch = "m";
			6'o22: ch = "p";
			6'o23: ch = ";";
			6'o30: ch = "q";
			6'o31: ch = "u";
			6'o32: ch = "o";
			6'o33: ch = "t";
			6'o34: ch = ";";
			6'o40: ch = "a";
			6'o41: ch = "p";
			6'o42: ch = "o";
			6'o43: ch = "s";
			6'o44: ch = ";";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic pos_t ent_len(input ent_idx_t ent);
		pos_t len;
		case (ent)
			3'd0: len = 3'd3;
			3'd1: len = 3'd3;
			3'd2: len = 3'd4;
			3'd3: len = 3'd5;
			3'd4: len = 3'd5;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic byte_t ent_char(input ent_idx_t ent);
		byte_t ch;
		case (ent)
			3'd0: ch = "<";
			3'd1: ch = ">";
			3'd2: ch = "&";
			3'd3: ch = 8'h22;
			3'd4: ch = 8'h27;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

### rtl/xed_front.sv
// front end: entity matcher, holds the open match and builds at most one job per input
// depends on xed_pkg
module xed_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  xed_pkg::byte_t  in_byte,
	input  logic            value_end,
	output logic            job_vld,
	output xed_pkg::job_t   job
);
	import xed_pkg::*;

	logic                  matching_q;
	cand_t                 mask_q;
	pos_t                  len_q;
	byte_t [HoldDepth-1:0] held_q;

	logic                  matching_nx;
	cand_t                 mask_nx;
	pos_t                  len_nx;
	byte_t [HoldDepth-1:0] held_nx;

	cand_t    next_cand;
	logic     done_any;
	ent_idx_t done_idx;
	logic     fresh;

	always_comb begin
		next_cand = '0;
		done_any  = 1'b0;
		done_idx  = '0;
		for (int i = 0; i < EntCount; i++) begin
			if (mask_q[i] && (len_q < ent_len(3'(i))) &&
			    (ent_name(3'(i), len_q) == in_byte)) begin
				if (len_q + 3'd1 == ent_len(3'(i))) begin
					done_any = 1'b1;
					done_idx = 3'(i);
				end else begin
					next_cand[i] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		matching_nx = matching_q;
		mask_nx     = mask_q;
		len_nx      = len_q;
		held_nx     = held_q;
		job         = '0;
		fresh       = 1'b1;
		if (matching_q) begin
			if (done_any) begin
				job.has_tail = 1'b1;
				job.tail     = ent_char(done_idx);
				matching_nx  = 1'b0;
				mask_nx      = '0;
				len_nx       = '0;
				fresh        = 1'b0;
			end else if ((next_cand != '0) && !len_q[2]) begin
				held_nx[len_q[1:0]] = in_byte;
				len_nx  = len_q + 3'd1;
				mask_nx = next_cand;
				fresh   = 1'b0;
				if (value_end) begin
					// value ends inside an open match
					job.flush   = 1'b1;
					job.nheld   = len_q + 3'd1;
					matching_nx = 1'b0;
					mask_nx     = '0;
					len_nx      = '0;
				end
			end else begin
				job.flush   = 1'b1;
				job.nheld   = len_q;
				matching_nx = 1'b0;
				mask_nx     = '0;
				len_nx      = '0;
			end
		end
		if (fresh) begin
			if (in_byte == AmpChar) begin
				if (value_end) begin
					job.has_tail = 1'b1;
					job.tail_bad = 1'b1;
					job.tail     = AmpChar;
				end else begin
					matching_nx = 1'b1;
					mask_nx     = AllCand;
					len_nx      = '0;
				end
			end else begin
				job.has_tail = 1'b1;
				job.tail     = in_byte;
			end
		end
		job.held     = held_nx;
		job.last_end = value_end;
	end

	assign job_vld = job.flush | job.has_tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matching_q <= 1'b0;
			mask_q     <= '0;
			len_q      <= '0;
		end else if (take) begin
			matching_q <= matching_nx;
			mask_q     <= mask_nx;
			len_q      <= len_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= held_nx;
		end
	end

endmodule

### rtl/xed_queue.sv
// two-entry job queue between the matcher and the output sequencer
// depends on xed_pkg
module xed_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xed_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output xed_pkg::job_t  head
);
	import xed_pkg::*;

	job_t       slot_q [QueueDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'(QueueDepth));
	assign nonempty = (count_q != 2'd0);
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### rtl/xed_back.sv
// back end: walks one job and sends its bytes one transfer per cycle while out_ready is high
// depends on xed_pkg
module xed_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_avail,
	input  xed_pkg::job_t  job_head,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output xed_pkg::byte_t out_byte,
	output logic           run_last,
	output logic           value_done,
	output logic           bad_entity
);
	import xed_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [2:0] idx_q;

	logic [2:0] total;
	logic [2:0] held_pos;
	logic       is_last;
	logic       sent;

	assign total    = {2'b00, job_q.flush} + job_q.nheld + {2'b00, job_q.has_tail};
	assign held_pos = idx_q - {2'b00, job_q.flush};
	assign is_last  = (idx_q == total - 3'd1);
	assign sent     = out_valid && out_ready;

	always_comb begin
		out_byte   = job_q.tail;
		bad_entity = job_q.tail_bad;
		if (job_q.flush && (idx_q == 3'd0)) begin
			out_byte   = AmpChar;
			bad_entity = 1'b1;
		end else if (held_pos < job_q.nheld) begin
			out_byte   = job_q.held[held_pos[1:0]];
			bad_entity = 1'b0;
		end
	end

	assign out_valid  = busy_q;
	assign run_last   = is_last;
	assign value_done = is_last && job_q.last_end;
	assign job_pop    = job_avail && (!busy_q || (sent && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (job_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (sent) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_head;
		end
	end

endmodule

### rtl/xml_entity_decoder_core.sv
// top level of the xml predefined entity decoder
// depends on xed_pkg, xed_front, xed_queue, xed_back
//
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  in      | in_valid, in_ready, in_byte, value_end       | in
//  out     | out_valid, out_ready, out_byte, run_last,    | out
//          | value_done, bad_entity                       |
//
// one input byte is taken per cycle while the two-entry job queue has room
// each result byte is one transfer of the output sequencer; a failed match
// gives up to six, so with a ready output input is held off only while such a burst drains
// an input transfer reaches the output through the queue slot and then the back end job register
// reset clears the match state and the queue; held bytes need no reset
// a stalled output only blocks input once the queue is full
module xml_entity_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  xed_pkg::byte_t in_byte,
	input  logic           value_end,
	output logic           out_valid,
	input  logic           out_ready,
	output xed_pkg::byte_t out_byte,
	output logic           run_last,
	output logic           value_done,
	output logic           bad_entity
);
	import xed_pkg::*;

	logic take;
	logic job_vld;
	job_t job_new;
	logic q_full;
	logic q_nonempty;
	job_t q_head;
	logic q_pop;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	xed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.value_end (value_end),
		.job_vld   (job_vld),
		.job       (job_new)
	);

	xed_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && job_vld),
		.push_job (job_new),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	xed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (q_nonempty),
		.job_head   (q_head),
		.job_pop    (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.value_done (value_done),
		.bad_entity (bad_entity)
	);

	// a bad entity flag only ever rides on an ampersand
	a_bad_is_amp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_entity) |-> (out_byte == AmpChar))
		else $error("bad_entity set on a byte other than ampersand");

	// end of value only on the last byte of a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && value_done) |-> run_last)
		else $error("value_done without run_last");

	// never pop an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("job queue popped while empty");

	// no input transfer while the job queue is full
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !take)
		else $error("input taken while job queue full");

endmodule
